// ===== sv/qmkb_pkg.sv =====
package qmkb_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_MOVE    = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_key;
    logic [4:0]  fill_count;
  } rsp_t;

endpackage

// ===== sv/queue_move_key_to_back.sv =====
// A command is registered in in_cmd_r, and its result in out_rsp_r, which drives out_rsp
// with out_valid high for a single cycle.
// Throughput: one command per cycle; busy is always low, as the compare-and-shift
// logic finishes every command without a stall.
// Reset (rst_n low at a rising edge) empties the queue and drops commands in flight;
// the stored keys are not cleared. The receiver cannot stall the result.
module queue_move_key_to_back #(
  parameter int QUEUE_DEPTH = qmkb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  qmkb_pkg::cmd_t  in_cmd,
  output logic            out_valid,
  output qmkb_pkg::rsp_t  out_rsp
);
  import qmkb_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                  in_vld_r;
  cmd_t                  in_cmd_r;
  logic [31:0]           keys_r   [QUEUE_DEPTH];
  logic [31:0]           keys_nxt [QUEUE_DEPTH];
  logic [31:0]           keys_up  [QUEUE_DEPTH];
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_vld_r;
  rsp_t                  out_rsp_r;
  rsp_t                  rsp_nxt;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] from_match;
  logic                  full;
  logic                  empty;
  logic                  found;

  assign busy      = 1'b0;
  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

  // Each slot's neighbour towards the tail, used when closing a gap.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_up
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      assign keys_up[g] = keys_r[g + 1];
    end else begin : g_last
      assign keys_up[g] = keys_r[g];
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (CW'(i) < count_r) && (keys_r[i] == in_cmd_r.key);
    end
  end

  // Bits at and above the first match, counted from the head.
  assign from_match = match | (~match + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1});
  assign found      = |match;
  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);

  always_comb begin
    keys_nxt           = keys_r;
    count_nxt          = count_r;
    rsp_nxt.status     = ST_DONE;
    rsp_nxt.result_key = '0;
    unique case (in_cmd_r.kind)
      KIND_ENQUEUE: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (CW'(i) == count_r) begin
              keys_nxt[i] = in_cmd_r.key;
            end
          end
          count_nxt          = count_r + CW'(1);
          rsp_nxt.result_key = in_cmd_r.key;
        end
      end
      KIND_DEQUEUE: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          keys_nxt           = keys_up;
          count_nxt          = count_r - CW'(1);
          rsp_nxt.result_key = keys_r[0];
        end
      end
      KIND_MOVE: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else if (!found) begin
          rsp_nxt.status = ST_MISSING;
        end else begin
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (from_match[i]) begin
              keys_nxt[i] = (CW'(i) == count_r - CW'(1)) ? in_cmd_r.key : keys_up[i];
            end
          end
          rsp_nxt.result_key = in_cmd_r.key;
        end
      end
      default: begin
      end
    endcase
    rsp_nxt.fill_count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd_r <= in_cmd;
    end
    if (in_vld_r) begin
      keys_r    <= keys_nxt;
      out_rsp_r <= rsp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("fill count exceeds the queue depth");

  a_result_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_vld_r)
    else $error("registered command gave no result");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> $stable(count_r))
    else $error("fill count changed without a command");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_rsp_r.status == ST_FULL |-> out_rsp_r.fill_count == 5'(QUEUE_DEPTH))
    else $error("full status with a queue that is not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_rsp_r.status == ST_EMPTY |-> out_rsp_r.fill_count == 5'd0)
    else $error("empty status with a queue that is not empty");
`endif

endmodule

// ===== tb/sv/move_queue_checker.sv =====
module move_queue_checker #(
  parameter int QUEUE_DEPTH = qmkb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  qmkb_pkg::cmd_t in_cmd,
  input  logic           out_valid,
  input  qmkb_pkg::rsp_t out_rsp,
  output int             mismatch_count,
  output int             pending_count
);
  import qmkb_pkg::*;

  localparam int REPORT_LIMIT = 40;

  logic [31:0] shadow_keys [QUEUE_DEPTH];
  int          shadow_count;
  rsp_t        expected_rsps [$];
  int          reported;

  // Closes the gap left by the entry at slot pos; the count drops by one.
  function automatic void close_gap(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_keys[i] = shadow_keys[i + 1];
    end
    shadow_count--;
  endfunction

  function automatic rsp_t apply_command(cmd_t cmd);
    rsp_t rsp;
    int   pos;
    rsp.status     = ST_DONE;
    rsp.result_key = '0;
    case (cmd.kind)
      KIND_ENQUEUE: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = cmd.key;
          shadow_count++;
          rsp.result_key = cmd.key;
        end
      end
      KIND_DEQUEUE: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.result_key = shadow_keys[0];
          close_gap(0);
        end
      end
      KIND_MOVE: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          pos = -1;
          for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_keys[i] == cmd.key) pos = i;
          end
          if (pos < 0) begin
            rsp.status = ST_MISSING;
          end else begin
            close_gap(pos);
            shadow_keys[shadow_count] = cmd.key;
            shadow_count++;
            rsp.result_key = cmd.key;
          end
        end
      end
      default: begin
        // The spare command code leaves the queue alone.
      end
    endcase
    rsp.fill_count = shadow_count[4:0];
    return rsp;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (!rst_n) begin
      expected_rsps.delete();
      shadow_count = 0;
      reported = 0;
      mismatch_count <= 0;
      pending_count <= 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_rsps.size() == 0) begin
          errs++;
          if (reported < REPORT_LIMIT) begin
            $display("%0t: result with nothing expected: status %0d key %h fill %0d",
                     $time, out_rsp.status, out_rsp.result_key, out_rsp.fill_count);
          end
          reported++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp.status !== want.status) errs++;
          if (out_rsp.result_key !== want.result_key) errs++;
          if (out_rsp.fill_count !== want.fill_count) errs++;
          if (errs != 0) begin
            if (reported < REPORT_LIMIT) begin
              $display("%0t: expected status %0d key %h fill %0d, got status %0d key %h fill %0d",
                       $time, want.status, want.result_key, want.fill_count,
                       out_rsp.status, out_rsp.result_key, out_rsp.fill_count);
            end
            reported++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_rsps.push_back(apply_command(in_cmd));
      end
      mismatch_count <= mismatch_count + errs;
      pending_count <= expected_rsps.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import qmkb_pkg::*;

  // The block leaves command code three unused; it must act as a no-op.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int         RANDOM_ITEMS = 1850;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  cmd_t in_cmd;
  logic out_valid;
  rsp_t out_rsp;
  int   mismatch_count;
  int   pending_count;

  logic [31:0] key_pool [6];
  logic [31:0] recent_keys [8];
  int          recent_idx;

  queue_move_key_to_back DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  move_queue_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .out_valid      (out_valid),
    .out_rsp        (out_rsp),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Leaves start high on return so that a following item goes out back to back.
  task automatic send_cmd(input logic [1:0] kind, input logic [31:0] key);
    in_cmd <= '{kind: kind, key: key};
    start <= 1'b1;
    if (kind == KIND_ENQUEUE) begin
      recent_keys[recent_idx] = key;
      recent_idx = (recent_idx + 1) % 8;
    end
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    in_cmd <= '{kind: 2'($urandom), key: $urandom};
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    logic [1:0]  kind;
    logic [31:0] key;
    int          sent;
    int          burst_len;
    int          mode;
    int          roll;
    bit          drained;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    recent_idx = 0;
    sent = 0;
    drained = 1'b0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) key_pool[i] = $urandom;
    for (int i = 0; i < 8; i++) recent_keys[i] = key_pool[i % 6];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty cases, spare code, fill to the brim, overflow,
    // moving the tail, moving the first of two equal keys, a miss and a dequeue.
    send_cmd(KIND_DEQUEUE, 32'hFFFF_FFFF);
    send_cmd(KIND_MOVE, 32'h0000_0000);
    send_cmd(KIND_SPARE, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) begin
      key = (i == 1) ? 32'hFFFF_FFFF : (i == 6) ? 32'h0 : 32'h0101_0101 * i;
      send_cmd(KIND_ENQUEUE, key);
    end
    send_cmd(KIND_ENQUEUE, 32'hDEAD_BEEF);
    send_cmd(KIND_MOVE, 32'h0F0F_0F0F);
    send_cmd(KIND_MOVE, 32'h0000_0000);
    send_cmd(KIND_MOVE, 32'h1234_5678);
    send_cmd(KIND_SPARE, 32'h0000_0000);
    send_cmd(KIND_DEQUEUE, 32'h0000_0000);
    hold_off(3);

    // Random bursts, each leaning to filling, draining or mildly filling, so the
    // queue swings between empty and full while moves mostly hit held keys.
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 40);
      mode = $urandom_range(0, 2);
      for (int b = 0; b < burst_len; b++) begin
        roll = $urandom_range(0, 99);
        if (roll < ((mode == 0) ? 55 : (mode == 1) ? 25 : 38)) begin
          kind = KIND_ENQUEUE;
        end else if (roll < ((mode == 0) ? 70 : 62 + 8 * (mode == 1))) begin
          kind = KIND_DEQUEUE;
        end else if (roll < 97) begin
          kind = KIND_MOVE;
        end else begin
          kind = KIND_SPARE;
        end
        roll = $urandom_range(0, 99);
        if (kind == KIND_MOVE) begin
          key = (roll < 70) ? recent_keys[$urandom_range(0, 7)] :
                (roll < 85) ? key_pool[$urandom_range(0, 5)] : $urandom;
        end else if (kind == KIND_ENQUEUE) begin
          key = (roll < 30) ? $urandom : key_pool[$urandom_range(0, 5)];
        end else begin
          key = $urandom;
        end
        send_cmd(kind, key);
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        hold_off(1);
        while (pending_count != 0) @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 8));
      end
    end

    hold_off(1);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("queue_move_key_to_back: match");
    end else begin
      $display("queue_move_key_to_back: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("queue_move_key_to_back: mismatch");
    $finish;
  end

endmodule
